FILE: rtl/bmsd_pkg.sv
// ----------------------------------------------------------------------------
// bmsd_pkg
// Shared types and constants for the binary mask square dilation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmsd_pkg;

    localparam int MAX_COLS   = 48;
    localparam int MAX_OFFSET = 8;
    localparam int HIST_DEPTH = 16;
    localparam int IN_W       = 48;
    localparam int ROW_W      = 64;
    localparam int COLS_W     = 6;
    localparam int OFF_W      = 4;
    localparam int WIN_W      = 5;
    localparam int CFG_W      = 6;

    typedef enum logic {
        REG_MASK_COLS       = 1'b0,
        REG_DILATION_OFFSET = 1'b1
    } cfg_idx_t;

    // one widened request handed from front to back
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             last;
        logic [WIN_W-1:0] win;
    } req_t;

    // queue head as seen by the consumer
    typedef struct packed {
        logic empty;
        req_t head;
    } req_q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/bmsd_front.sv
// ----------------------------------------------------------------------------
// bmsd_front
// Holds the configuration and widens each incoming row horizontally.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsd_front
    import bmsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire cfg_idx_t         cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic [IN_W-1:0]  row_bits,
    input  wire logic             last_row,
    output req_t                  req
);

    logic [COLS_W-1:0] cols_reg;
    logic [OFF_W-1:0]  offset_reg;
    logic [COLS_W-1:0] cols_eff;
    logic [OFF_W-1:0]  offset_eff;
    logic [WIN_W-1:0]  win;
    logic [IN_W-1:0]   row_masked;
    logic [ROW_W-1:0]  wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= COLS_W'(MAX_COLS);
            offset_reg <= OFF_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MASK_COLS:       cols_reg   <= cfg_data;
                REG_DILATION_OFFSET: offset_reg <= cfg_data[OFF_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = COLS_W'(1);
        else if (cols_reg > COLS_W'(MAX_COLS))
            cols_eff = COLS_W'(MAX_COLS);
        else
            cols_eff = cols_reg;

        if (offset_reg > OFF_W'(MAX_OFFSET))
            offset_eff = OFF_W'(MAX_OFFSET);
        else
            offset_eff = offset_reg;
        win = {offset_eff, 1'b0};

        for (int j = 0; j < IN_W; j++)
            row_masked[j] = row_bits[j] & (COLS_W'(j) < cols_eff);

        wide = '0;
        for (int s = 0; s <= 2 * MAX_OFFSET; s++)
        begin
            if (WIN_W'(s) <= win)
                wide = wide | (ROW_W'(row_masked) << s);
        end

        req.row  = wide;
        req.last = last_row;
        req.win  = win;
    end

endmodule

`default_nettype wire

FILE: rtl/bmsd_queue.sv
// ----------------------------------------------------------------------------
// bmsd_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsd_queue
    import bmsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire req_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output req_q_stat_t stat
);

    req_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign full       = (cnt_reg == 2'd2);
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && (cnt_reg != 2'd0);
    assign stat.empty = (cnt_reg == 2'd0);
    assign stat.head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bmsd_back.sv
// ----------------------------------------------------------------------------
// bmsd_back
// Row history, vertical OR, end-of-mask drain and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsd_back
    import bmsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire req_q_stat_t      q_stat,
    output logic                  q_pop,
    input  wire logic             pop,
    output logic                  empty,
    output logic [ROW_W-1:0]      grown_row,
    output logic                  final_row
);

    logic [ROW_W-1:0] hist_reg [HIST_DEPTH];
    logic             flush_reg;
    logic [WIN_W-1:0] rem_reg;
    logic [WIN_W-1:0] fwin_reg;

    logic [ROW_W-1:0] out_row_mem [2];
    logic             out_fin_mem [2];
    logic             out_wr_ptr_reg;
    logic             out_rd_ptr_reg;
    logic [1:0]       out_cnt_reg;

    logic [WIN_W-1:0] hl;
    logic [ROW_W-1:0] hor;
    logic             emit_ok;
    logic             do_item;
    logic             do_flush;
    logic             res_wr;
    logic [ROW_W-1:0] res_row;
    logic             res_fin;
    logic             out_rd;

    always_comb
    begin
        // during drain the new head is zero, so only older taps count
        hl = flush_reg ? (fwin_reg - WIN_W'(1)) : q_stat.head.win;
        hor = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            if (WIN_W'(i) < hl)
                hor = hor | hist_reg[i];
        end

        emit_ok  = (out_cnt_reg != 2'd2);
        do_flush = flush_reg && emit_ok;
        do_item  = !flush_reg && !q_stat.empty && emit_ok;
        q_pop    = do_item;
        res_wr   = do_flush || do_item;

        if (flush_reg)
        begin
            res_row = hor;
            res_fin = (rem_reg == WIN_W'(1));
        end
        else
        begin
            res_row = q_stat.head.row | hor;
            res_fin = q_stat.head.last && (q_stat.head.win == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= '0;
            flush_reg <= 1'b0;
            rem_reg   <= '0;
            fwin_reg  <= '0;
        end
        else if (do_item)
        begin
            // a last row with no window ends the mask at once
            if (q_stat.head.last && (q_stat.head.win == '0))
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                    hist_reg[i] <= '0;
            end
            else
            begin
                hist_reg[0] <= q_stat.head.row;
                for (int i = 1; i < HIST_DEPTH; i++)
                    hist_reg[i] <= hist_reg[i-1];
            end
            if (q_stat.head.last && (q_stat.head.win != '0))
            begin
                flush_reg <= 1'b1;
                rem_reg   <= q_stat.head.win;
                fwin_reg  <= q_stat.head.win;
            end
        end
        else if (do_flush)
        begin
            if (rem_reg == WIN_W'(1))
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                    hist_reg[i] <= '0;
                flush_reg <= 1'b0;
            end
            else
            begin
                hist_reg[0] <= '0;
                for (int i = 1; i < HIST_DEPTH; i++)
                    hist_reg[i] <= hist_reg[i-1];
            end
            rem_reg <= rem_reg - WIN_W'(1);
        end
    end

    // result queue
    assign out_rd    = pop && (out_cnt_reg != 2'd0);
    assign empty     = (out_cnt_reg == 2'd0);
    assign grown_row = out_row_mem[out_rd_ptr_reg];
    assign final_row = out_fin_mem[out_rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (res_wr)
        begin
            out_row_mem[out_wr_ptr_reg] <= res_row;
            out_fin_mem[out_wr_ptr_reg] <= res_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (res_wr)
                out_wr_ptr_reg <= !out_wr_ptr_reg;
            if (out_rd)
                out_rd_ptr_reg <= !out_rd_ptr_reg;
            out_cnt_reg <= out_cnt_reg + 2'(res_wr) - 2'(out_rd);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/binary_mask_square_dilation.sv
// ----------------------------------------------------------------------------
// binary_mask_square_dilation
// A row passes the request queue, then the result queue, to the result side.
// Throughput: one row per cycle while the result queue has room; a last row
// with offset k holds the back end while history drains through the row OR.
// Reset: asynchronous, active low; clears queues, history and sets
// mask_cols to 48 and dilation_offset to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_mask_square_dilation
    import bmsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire cfg_idx_t         cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [IN_W-1:0]  row_bits,
    input  wire logic             last_row,
    input  wire logic             pop,
    output logic                  empty,
    output logic [ROW_W-1:0]      grown_row,
    output logic                  final_row
);

    req_t        req;
    req_q_stat_t q_stat;
    logic        q_pop;

    assign cfg_ready = 1'b1;

    bmsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row_bits  (row_bits),
        .last_row  (last_row),
        .req       (req)
    );

    bmsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (req),
        .full    (full),
        .rd_en   (q_pop),
        .stat    (q_stat)
    );

    bmsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .grown_row (grown_row),
        .final_row (final_row)
    );

endmodule

`default_nettype wire

FILE: test/binary_mask_square_dilation_tb.sv
// ----------------------------------------------------------------------------
// binary_mask_square_dilation_tb
// Self-checking bench for the square dilation block. Mask rows go in through
// the push/full side and grown rows come back through empty/pop. A local
// predictor widens each accepted request, ORs it with its own row history and
// queues the grown rows due, including the trailing rows of the end-of-mask
// flush. Directed cases cover the register limits and stale history. Random
// masks then run under three stall patterns with config changes between masks.
// ----------------------------------------------------------------------------
module binary_mask_square_dilation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmsd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             fin;
    } grown_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             push;
    logic             full;
    logic [IN_W-1:0]  row_bits;
    logic             last_row;
    logic             pop = 1'b0;
    logic             empty;
    logic [ROW_W-1:0] grown_row;
    logic             final_row;

    grown_t           grown_rows_due[$];
    logic [COLS_W-1:0] cols_setting;
    logic [OFF_W-1:0]  offset_setting;
    logic [ROW_W-1:0]  widened_hist [HIST_DEPTH];

    int send_idle_pct = 0;
    int pop_idle_pct  = 0;
    int rows_sent     = 0;
    int error_count   = 0;
    int stall_cycles  = 0;

    binary_mask_square_dilation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .row_bits  (row_bits),
        .last_row  (last_row),
        .pop       (pop),
        .empty     (empty),
        .grown_row (grown_row),
        .final_row (final_row)
    );

    always #5ns clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [ROW_W-1:0] history_or(input int unsigned n);
        logic [ROW_W-1:0] acc;
        acc = '0;
        for (int unsigned i = 0; i < n && i < HIST_DEPTH; i++)
            acc |= widened_hist[i];
        return acc;
    endfunction

    function automatic void shift_history(input logic [ROW_W-1:0] row);
        for (int i = HIST_DEPTH - 1; i > 0; i--)
            widened_hist[i] = widened_hist[i-1];
        widened_hist[0] = row;
    endfunction

    function automatic void predict_grown_rows(input logic [IN_W-1:0] bits,
                                               input logic last);
        int unsigned      cols;
        int unsigned      k;
        int unsigned      win;
        logic [ROW_W-1:0] src;
        logic [ROW_W-1:0] wide;
        grown_t           g;
        cols = (cols_setting == 0) ? 1 :
               (cols_setting > MAX_COLS) ? MAX_COLS : cols_setting;
        k    = (offset_setting > MAX_OFFSET) ? MAX_OFFSET : offset_setting;
        win  = 2 * k;
        src  = {{(ROW_W-IN_W){1'b0}}, bits} & ((64'd1 << cols) - 64'd1);
        wide = '0;
        for (int unsigned s = 0; s <= win; s++)
            wide |= src << s;
        g.row = wide | history_or(win);
        g.fin = last && (win == 0);
        grown_rows_due.push_back(g);
        shift_history(wide);
        if (last)
        begin
            for (int unsigned t = 0; t < win; t++)
            begin
                shift_history('0);
                g.row = history_or(win);
                g.fin = (t + 1 == win);
                grown_rows_due.push_back(g);
            end
            foreach (widened_hist[i])
                widened_hist[i] = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_row(input logic [IN_W-1:0] bits, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        row_bits <= bits;
        last_row <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_grown_rows(bits, last);
        rows_sent++;
    endtask

    // leaves cfg_valid high; set_config lowers it after the last request
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MASK_COLS)
            cols_setting = data;
        else
            offset_setting = data[OFF_W-1:0];
    endtask

    task automatic set_config(input logic [CFG_W-1:0] cols,
                              input logic [CFG_W-1:0] offset);
        write_reg(REG_MASK_COLS, cols);
        write_reg(REG_DILATION_OFFSET, offset);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (grown_rows_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] rand_row();
        logic [IN_W-1:0] r;
        case ($urandom_range(9))
            0, 1, 2, 3: r = IN_W'(1) << $urandom_range(IN_W - 1);
            4:          r = (IN_W'(1) << $urandom_range(IN_W - 1)) |
                            (IN_W'(1) << $urandom_range(IN_W - 1));
            5:          r = '0;
            6, 7:       r = IN_W'({$urandom, $urandom});
            8:          r = IN_W'({$urandom, $urandom}) & IN_W'({$urandom, $urandom})
                            & IN_W'({$urandom, $urandom});
            default:    r = '1;
        endcase
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pick_cols();
        case ($urandom_range(5))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd48;
            3:       return 6'd63;
            default: return CFG_W'($urandom_range(1, MAX_COLS));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_offset();
        case ($urandom_range(5))
            0:       return 6'd0;
            1:       return 6'd8;
            2:       return 6'd15;
            3:       return CFG_W'($urandom_range(63));
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result checker and pop driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_rows
        grown_t want;
        if (rst_n && pop && !empty)
        begin
            if (grown_rows_due.size() == 0)
            begin
                $display("%0t: unexpected row, expected none, actual row %h final %b",
                         $time, grown_row, final_row);
                error_count++;
            end
            else
            begin
                want = grown_rows_due.pop_front();
                if (grown_row !== want.row)
                begin
                    $display("%0t: grown_row expected %h actual %h",
                             $time, want.row, grown_row);
                    error_count++;
                end
                if (final_row !== want.fin)
                begin
                    $display("%0t: final_row expected %b actual %b",
                             $time, want.fin, final_row);
                    error_count++;
                end
            end
        end
        pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_default_config();
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row(IN_W'(1), 1'b0);
        send_row(IN_W'(1) << (IN_W - 1), 1'b1);
        wait_drained();
    endtask

    task automatic test_column_limits();
        set_config(6'd0, 6'd2);
        send_row('1, 1'b1);
        wait_drained();
        set_config(6'd63, 6'd2);
        send_row({(IN_W/2){2'b10}}, 1'b0);
        send_row('1, 1'b1);
        wait_drained();
        set_config(6'd5, 6'd1);
        send_row('1, 1'b1);
        wait_drained();
    endtask

    task automatic test_offset_limits();
        set_config(6'd48, 6'd0);
        send_row({(IN_W/2){2'b01}}, 1'b0);
        send_row('1, 1'b1);
        wait_drained();
        set_config(6'd48, 6'd8);
        send_row(IN_W'(1), 1'b0);
        send_row(IN_W'(1) << (IN_W - 1), 1'b1);
        wait_drained();
        set_config(6'd48, 6'd15);
        send_row(IN_W'(1) << 20, 1'b0);
        send_row('0, 1'b1);
        wait_drained();
        // upper data bits are dropped by the offset register
        set_config(6'd48, 6'h33);
        send_row(IN_W'(1) << 3, 1'b0);
        send_row(IN_W'(1) << 40, 1'b1);
        wait_drained();
    endtask

    // history entries beyond the old window are read once k grows mid-mask
    task automatic test_stale_history();
        set_config(6'd16, 6'd1);
        for (int r = 0; r < 6; r++)
            send_row(IN_W'(1) << (2 * r), 1'b0);
        wait_drained();
        set_config(6'd16, 6'd8);
        send_row(IN_W'(1) << 15, 1'b0);
        send_row('0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_masks(input int send_pct, input int pop_pct,
                                     input int n_rows);
        int start;
        int len;
        bit broken;
        send_idle_pct = send_pct;
        pop_idle_pct  = pop_pct;
        start = rows_sent;
        while (rows_sent - start < n_rows)
        begin
            if ($urandom_range(9) < 3)
            begin
                wait_drained();
                set_config(pick_cols(), pick_offset());
            end
            len    = $urandom_range(1, 8);
            broken = ($urandom_range(9) == 0);
            for (int r = 0; r < len; r++)
                send_row(rand_row(), !broken && (r == len - 1));
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MASK_COLS;
        cfg_data  <= '0;
        push      <= 1'b0;
        row_bits  <= '0;
        last_row  <= 1'b0;
        cols_setting   = 6'd48;
        offset_setting = 4'd1;
        foreach (widened_hist[i])
            widened_hist[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        pop_idle_pct  = 63;
        test_default_config();
        test_column_limits();
        test_offset_limits();
        test_stale_history();

        test_random_masks(36, 63, 137);
        test_random_masks(63, 36, 137);
        test_random_masks(0, 0, 136);

        repeat (10) @(posedge clk);
        if (error_count == 0 && grown_rows_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
